FILE: rtl/sat_pkg.sv
// Shared types and constants for the section address translator.
package sat_pkg;

   // Default table depth
   localparam int SAT_MAX_SECTIONS = 16;

   // Register file: two registers at byte addresses 0 and 4
   localparam int          CSR_AW      = 3;
   localparam logic        CSR_ALIGN   = 1'b0;
   localparam logic        CSR_COUNT   = 1'b1;
   localparam logic [31:0] ALIGN_RESET = 32'd4096;

   // Request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_XLATE = 1'b1;

   // One section table entry
   typedef struct packed {
      logic [31:0] vstart;
      logic [31:0] vsize;
      logic [31:0] raw;
   } entry_type;

   // Operands for the shared adder and comparator
   typedef struct packed {
      logic [31:0] add_a;
      logic [31:0] add_b;
      logic        add_sub;
      logic [31:0] cmp_a;
      logic [31:0] cmp_b;
   } alu_req_type;

   // Adder sum, carry out and comparator result (cmp_a < cmp_b)
   typedef struct packed {
      logic [31:0] sum;
      logic        carry;
      logic        less;
   } alu_res_type;

   // Walk sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_ROUND,
      ST_BOUND,
      ST_CHECK,
      ST_APPLY,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/sat_alu.sv
// Shared 32-bit add/subtract unit with an unsigned less-than comparator.
module sat_alu (
   input  sat_pkg::alu_req_type req,
   output sat_pkg::alu_res_type res
);

   logic [31:0] b_op;
   logic [32:0] sum_wide;

   // Subtract as a + ~b + 1
   assign b_op     = req.add_sub ? ~req.add_b : req.add_b;
   assign sum_wide = {1'b0, req.add_a} + {1'b0, b_op} + {32'd0, req.add_sub};

   assign res.sum   = sum_wide[31:0];
   assign res.carry = sum_wide[32];
   assign res.less  = req.cmp_a < req.cmp_b;

endmodule

FILE: rtl/section_address_translator.sv
// Top level of the section address translator: table, sequencer and register port.
//
//  channel  ports                          handshake
//  request  start, busy, req_*             taken when start is high and busy is low
//  response rsp_valid, rsp_*               one-cycle strobe, cannot be stalled
//  control  psel, penable, pwrite, paddr,  APB-style, pready always high
//           pwdata, prdata, pready
//
// A write request keeps busy low. A translate request walks
// N = min(section_count, MAX_SECTIONS) entries through one shared adder and
// comparator, in five steps per entry (table read, size rounding, end address,
// range check, offset add); busy stays high through the walk and the DONE state,
// in which the response strobe comes. Reset clears the sequencer and the registers;
// the table holds nothing defined until its entries are written.
module section_address_translator #(
   parameter int MAX_SECTIONS = sat_pkg::SAT_MAX_SECTIONS
) (
   input  logic                       clock,
   input  logic                       reset,
   // request
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_func,
   input  logic [3:0]                 req_entry_index,
   input  logic [31:0]                req_entry_virtual_start,
   input  logic [31:0]                req_entry_virtual_size,
   input  logic [31:0]                req_entry_raw_offset,
   input  logic [31:0]                req_lookup_address,
   // response
   output logic                       rsp_valid,
   output logic [31:0]                rsp_file_offset,
   output logic                       rsp_found,
   // control registers
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [sat_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

   sat_pkg::state_type   state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     lim_ff, lim_in;
   logic [CNT_W-1:0]     lim_req;
   logic [31:0]          addr_ff, addr_in;
   logic [31:0]          rnd_ff, rnd_in;
   logic                 ge_ff, ge_in;
   logic                 carry_ff, carry_in;
   logic [31:0]          end_ff, end_in;
   logic [31:0]          diff_ff, diff_in;
   logic                 hit_ff, hit_in;
   logic [31:0]          result_ff, result_in;
   logic                 found_ff, found_in;
   logic [31:0]          align_ff, align_in;
   logic [31:0]          mask_ff, mask_in;
   logic [4:0]           count_ff, count_in;

   sat_pkg::entry_type   mem [MAX_SECTIONS];
   sat_pkg::entry_type   rd_ff;
   sat_pkg::entry_type   wr_entry;
   logic                 accept;
   logic                 mem_we;
   logic                 csr_we;
   sat_pkg::alu_req_type alu_req;
   sat_pkg::alu_res_type alu_res;

   assign accept = start && !busy;
   assign csr_we = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   // Table write; indexes beyond the table are dropped
   assign mem_we = accept && (req_func == sat_pkg::FUNC_WRITE) &&
                   ({28'd0, req_entry_index} < 32'(MAX_SECTIONS));
   assign wr_entry.vstart = req_entry_virtual_start;
   assign wr_entry.vsize  = req_entry_virtual_size;
   assign wr_entry.raw    = req_entry_raw_offset;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[IDX_W'(req_entry_index)] <= wr_entry;
      end
   end

   // Registered read at the walk counter
   always_ff @(posedge clock) begin
      rd_ff <= mem[cnt_ff[IDX_W-1:0]];
   end

   // Entries taking part in a walk
   assign lim_req = ({27'd0, count_ff} > 32'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS)
                                                            : CNT_W'(count_ff);

   sat_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   // Register read
   always_comb begin
      unique case (paddr[2])
         sat_pkg::CSR_ALIGN: prdata = align_ff;
         sat_pkg::CSR_COUNT: prdata = {27'd0, count_ff};
         default:            prdata = 32'd0;
      endcase
   end

   // Sequencer: operand selection, next state and register updates
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      lim_in    = lim_ff;
      addr_in   = addr_ff;
      rnd_in    = rnd_ff;
      ge_in     = ge_ff;
      carry_in  = carry_ff;
      end_in    = end_ff;
      diff_in   = diff_ff;
      hit_in    = hit_ff;
      result_in = result_ff;
      found_in  = found_ff;
      align_in  = align_ff;
      mask_in   = mask_ff;
      count_in  = count_ff;
      alu_req   = '0;

      // Register writes; the mask is kept alongside the alignment
      if (csr_we) begin
         unique case (paddr[2])
            sat_pkg::CSR_ALIGN: begin
               align_in = pwdata;
               mask_in  = pwdata - 32'd1;
            end
            sat_pkg::CSR_COUNT: count_in = pwdata[4:0];
            default:            count_in = count_ff;
         endcase
      end

      unique case (state_ff)
         sat_pkg::ST_IDLE: begin
            if (accept && (req_func == sat_pkg::FUNC_XLATE)) begin
               addr_in   = req_lookup_address;
               lim_in    = lim_req;
               cnt_in    = '0;
               result_in = 32'd0;
               found_in  = 1'b0;
               state_in  = (lim_req == '0) ? sat_pkg::ST_DONE : sat_pkg::ST_FETCH;
            end
         end
         // Table read in flight
         sat_pkg::ST_FETCH: state_in = sat_pkg::ST_ROUND;
         // Round size up to the alignment; check addr >= start
         sat_pkg::ST_ROUND: begin
            alu_req.add_a = rd_ff.vsize & ~mask_ff;
            alu_req.add_b = align_ff;
            alu_req.cmp_a = addr_ff;
            alu_req.cmp_b = rd_ff.vstart;
            rnd_in   = ((rd_ff.vsize & mask_ff) != 32'd0) ? alu_res.sum : rd_ff.vsize;
            ge_in    = !alu_res.less;
            state_in = sat_pkg::ST_BOUND;
         end
         // End address; a carry means the range wraps and matches nothing
         sat_pkg::ST_BOUND: begin
            alu_req.add_a = rd_ff.vstart;
            alu_req.add_b = rnd_ff;
            carry_in = alu_res.carry;
            end_in   = alu_res.sum;
            state_in = sat_pkg::ST_CHECK;
         end
         // Offset into the section; check addr < end
         sat_pkg::ST_CHECK: begin
            alu_req.add_a   = addr_ff;
            alu_req.add_b   = rd_ff.vstart;
            alu_req.add_sub = 1'b1;
            alu_req.cmp_a   = addr_ff;
            alu_req.cmp_b   = end_ff;
            diff_in  = alu_res.sum;
            hit_in   = ge_ff && !carry_ff && alu_res.less;
            state_in = sat_pkg::ST_APPLY;
         end
         // Later matches override earlier ones
         sat_pkg::ST_APPLY: begin
            alu_req.add_a = diff_ff;
            alu_req.add_b = rd_ff.raw;
            if (hit_ff) begin
               result_in = alu_res.sum;
               found_in  = 1'b1;
            end
            cnt_in   = cnt_ff + CNT_W'(1);
            state_in = (cnt_in == lim_ff) ? sat_pkg::ST_DONE : sat_pkg::ST_FETCH;
         end
         sat_pkg::ST_DONE: state_in = sat_pkg::ST_IDLE;
         default:          state_in = sat_pkg::ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sat_pkg::ST_IDLE;
         align_ff <= sat_pkg::ALIGN_RESET;
         mask_ff  <= sat_pkg::ALIGN_RESET - 32'd1;
         count_ff <= 5'd0;
      end else begin
         state_ff <= state_in;
         align_ff <= align_in;
         mask_ff  <= mask_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      lim_ff    <= lim_in;
      addr_ff   <= addr_in;
      rnd_ff    <= rnd_in;
      ge_ff     <= ge_in;
      carry_ff  <= carry_in;
      end_ff    <= end_in;
      diff_ff   <= diff_in;
      hit_ff    <= hit_in;
      result_ff <= result_in;
      found_ff  <= found_in;
   end

   assign busy            = (state_ff != sat_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == sat_pkg::ST_DONE);
   assign rsp_file_offset = result_ff;
   assign rsp_found       = found_ff;

endmodule
